FILE: rtl/proximity_zone_dwell_controller_defines.svh
// ---------------------------------------------------------------------------
// Proximity zone dwell controller: assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ---------------------------------------------------------------------------
`ifndef PROXIMITY_ZONE_DWELL_CONTROLLER_DEFINES_SVH
`define PROXIMITY_ZONE_DWELL_CONTROLLER_DEFINES_SVH

// Checked only while out of reset.
`define PZDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PZDC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/pzdc_pkg.sv
// ---------------------------------------------------------------------------
// Proximity zone dwell controller package
// Zone codes, timer and register indexes, shared types and constants.
// ---------------------------------------------------------------------------
package pzdc_pkg;

	typedef enum logic [2:0] {
		ZONE_PERSONAL    = 3'd0,
		ZONE_PERS_SOCIAL = 3'd1,
		ZONE_SOCIAL      = 3'd2,
		ZONE_SOC_PUBLIC  = 3'd3,
		ZONE_PUBLIC      = 3'd4
	} zone_t;

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_DWELL_SOC_PUBLIC  = 2'd0,
		REG_DWELL_SOCIAL      = 2'd1,
		REG_DWELL_PERS_SOCIAL = 2'd2
	} reg_idx_t;

	localparam int DIST_W   = 16;
	localparam int CNT_W    = 16;
	localparam int TGT_W    = 12;
	localparam int NUM_TMR  = 3;

	typedef logic [1:0] tmr_idx_t;
	localparam tmr_idx_t TMR_SOC_PUBLIC  = 2'd0;
	localparam tmr_idx_t TMR_SOCIAL      = 2'd1;
	localparam tmr_idx_t TMR_PERS_SOCIAL = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [CNT_W-1:0] dwell_pers_social;
		logic [CNT_W-1:0] dwell_social;
		logic [CNT_W-1:0] dwell_soc_public;
	} dwell_cfg_t;

	typedef struct packed {
		logic [TGT_W-1:0] desired_distance_mm;
		zone_t            desired_zone;
		logic             zone_changed;
		zone_t            previous_zone;
		zone_t            current_zone;
	} result_t;

endpackage

FILE: rtl/pzdc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Dwell configuration registers
// Holds the three dwell limits written through the configuration channel.
// ---------------------------------------------------------------------------
module pzdc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output pzdc_pkg::dwell_cfg_t dwell_cfg
);
	import pzdc_pkg::*;

	dwell_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dwell_soc_public  <= CNT_W'(5);
			cfg_q.dwell_social      <= CNT_W'(5);
			cfg_q.dwell_pers_social <= CNT_W'(5);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DWELL_SOC_PUBLIC:  cfg_q.dwell_soc_public  <= cfg_data;
				REG_DWELL_SOCIAL:      cfg_q.dwell_social      <= cfg_data;
				REG_DWELL_PERS_SOCIAL: cfg_q.dwell_pers_social <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dwell_cfg = cfg_q;

endmodule

FILE: rtl/pzdc_core.sv
// ---------------------------------------------------------------------------
// Zone and dwell engine
// Classifies a measurement, updates zone, desired zone and dwell timers.
// ---------------------------------------------------------------------------
module pzdc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 op,
	input  logic [15:0]          distance_mm,
	input  pzdc_pkg::dwell_cfg_t dwell_cfg,
	output pzdc_pkg::result_t    result
);
	import pzdc_pkg::*;
	`include "proximity_zone_dwell_controller_defines.svh"

	zone_t            zone_q, zone_d;
	zone_t            tgt_q, tgt_d;
	zone_t            meas_zone;
	logic [CNT_W-1:0] cnt_q [NUM_TMR];
	logic [CNT_W-1:0] cnt_d [NUM_TMR];
	logic             run_q [NUM_TMR];
	logic             run_d [NUM_TMR];
	logic             changed;
	tmr_idx_t         step_tmr;
	logic [CNT_W-1:0] step_limit;
	zone_t            step_next;

	always_comb begin
		priority if (distance_mm > DIST_W'(4000)) meas_zone = ZONE_PUBLIC;
		else if (distance_mm > DIST_W'(3500))     meas_zone = ZONE_SOC_PUBLIC;
		else if (distance_mm > DIST_W'(2000))     meas_zone = ZONE_SOCIAL;
		else if (distance_mm > DIST_W'(1500))     meas_zone = ZONE_PERS_SOCIAL;
		else                                      meas_zone = ZONE_PERSONAL;
	end

	// Timer and limit that belong to the measured zone when it is held.
	always_comb begin
		step_next = zone_t'(meas_zone - 3'd1);
		unique case (meas_zone)
			ZONE_SOC_PUBLIC: begin
				step_tmr   = TMR_SOC_PUBLIC;
				step_limit = dwell_cfg.dwell_soc_public;
			end
			ZONE_SOCIAL: begin
				step_tmr   = TMR_SOCIAL;
				step_limit = dwell_cfg.dwell_social;
			end
			default: begin
				step_tmr   = TMR_PERS_SOCIAL;
				step_limit = dwell_cfg.dwell_pers_social;
			end
		endcase
	end

	always_comb begin
		zone_d  = zone_q;
		tgt_d   = tgt_q;
		cnt_d   = cnt_q;
		run_d   = run_q;
		changed = 1'b0;
		if (op_t'(op) == OP_TICK) begin
			for (int i = 0; i < NUM_TMR; i++) begin
				if (run_q[i] && cnt_q[i] != COUNT_MAX) begin
					cnt_d[i] = cnt_q[i] + CNT_W'(1);
				end
			end
		end else begin
			changed = (meas_zone != zone_q);
			zone_d  = meas_zone;
			if (changed) begin
				unique case (meas_zone)
					ZONE_PUBLIC: begin
						run_d[TMR_SOC_PUBLIC] = 1'b0;
						tgt_d = ZONE_SOC_PUBLIC;
					end
					ZONE_SOC_PUBLIC: begin
						cnt_d[TMR_SOC_PUBLIC] = '0;
						run_d[TMR_SOC_PUBLIC] = 1'b1;
						run_d[TMR_SOCIAL]     = 1'b0;
					end
					ZONE_SOCIAL: begin
						cnt_d[TMR_SOCIAL]      = '0;
						run_d[TMR_SOCIAL]      = 1'b1;
						run_d[TMR_PERS_SOCIAL] = 1'b0;
						run_d[TMR_SOC_PUBLIC]  = 1'b0;
					end
					ZONE_PERS_SOCIAL: begin
						cnt_d[TMR_PERS_SOCIAL] = '0;
						run_d[TMR_PERS_SOCIAL] = 1'b1;
						run_d[TMR_SOCIAL]      = 1'b0;
					end
					default: begin
						run_d[TMR_PERS_SOCIAL] = 1'b0;
					end
				endcase
			end else begin
				unique case (meas_zone)
					ZONE_PUBLIC: begin
						tgt_d = ZONE_SOC_PUBLIC;
					end
					ZONE_PERSONAL: begin
						run_d[TMR_PERS_SOCIAL] = 1'b0;
					end
					default: begin
						// Held zone: step closer once the dwell is met; a stopped timer is armed.
						if (tgt_q != step_next) begin
							if (run_q[step_tmr]) begin
								if (cnt_q[step_tmr] >= step_limit) begin
									tgt_d           = step_next;
									run_d[step_tmr] = 1'b0;
								end
							end else begin
								cnt_d[step_tmr] = '0;
								run_d[step_tmr] = 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_PUBLIC;
			tgt_q  <= ZONE_SOC_PUBLIC;
			for (int i = 0; i < NUM_TMR; i++) begin
				cnt_q[i] <= '0;
				run_q[i] <= 1'b0;
			end
		end else if (upd) begin
			zone_q <= zone_d;
			tgt_q  <= tgt_d;
			cnt_q  <= cnt_d;
			run_q  <= run_d;
		end
	end

	always_comb begin
		result.current_zone  = zone_d;
		result.previous_zone = zone_q;
		result.zone_changed  = changed;
		result.desired_zone  = tgt_d;
		unique case (tgt_d)
			ZONE_PERSONAL:    result.desired_distance_mm = TGT_W'(500);
			ZONE_PERS_SOCIAL: result.desired_distance_mm = TGT_W'(1500);
			ZONE_SOCIAL:      result.desired_distance_mm = TGT_W'(2000);
			ZONE_SOC_PUBLIC:  result.desired_distance_mm = TGT_W'(3500);
			default:          result.desired_distance_mm = TGT_W'(4000);
		endcase
	end

	// The desired zone is never the public zone itself.
	`PZDC_ASSERT(a_tgt_not_public, tgt_q != ZONE_PUBLIC, "desired zone is public")
	`PZDC_ASSERT(a_tick_keeps_zone, (upd && op) |=> $stable(zone_q), "tick moved the zone")
	`PZDC_ASSERT(a_tick_keeps_tgt, (upd && op) |=> $stable(tgt_q), "tick moved desired zone")
	`PZDC_ASSERT(a_cnt_saturates,
		(upd && op && run_q[TMR_SOCIAL] && cnt_q[TMR_SOCIAL] == COUNT_MAX)
		|=> (cnt_q[TMR_SOCIAL] == COUNT_MAX), "dwell count wrapped")

endmodule

FILE: rtl/proximity_zone_dwell_controller.sv
// ---------------------------------------------------------------------------
// Proximity zone dwell controller
// Sorts distances into five zones and steps the desired zone on dwell.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// s_*       in         tuser: op; tdata[15:0]: distance_mm
// m_*       out        tdata: zones, changed flag, desired distance (see port)
// cfg_*     in         cfg_index selects a dwell register, cfg_data its value
//
// One item per cycle unless m_tready stalls the output; a result passes the
// input register, then the result register behind the zone engine, before it
// is offered on m_*.
// The zone engine updates its state when an item moves to the result register.
// Reset clears zones, timers and both stages; dwell limits return to 5.
// A stalled m_tready holds the result and backs up through the input register.
// Configuration writes are taken in any cycle.
// ---------------------------------------------------------------------------
module proximity_zone_dwell_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] distance_mm
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] current_zone, [5:3] previous_zone,
	                               // [6] zone_changed, [9:7] desired_zone,
	                               // [21:10] desired_distance_mm, [23:22] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pzdc_pkg::*;

	logic              s1_valid_q;
	logic              op_s1;
	logic [DIST_W-1:0] dist_s1;
	logic              out_valid_q;
	result_t           result;
	result_t           out_q;
	dwell_cfg_t        dwell_cfg;
	logic              advance;
	logic              s_accept;

	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign s_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1   <= s_tuser;
			dist_s1 <= s_tdata;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	pzdc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dwell_cfg (dwell_cfg)
	);

	pzdc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (advance),
		.op          (op_s1),
		.distance_mm (dist_s1),
		.dwell_cfg   (dwell_cfg),
		.result      (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

FILE: sim/proximity_zone_dwell_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proximity zone dwell controller testbench
// Drives distance measurements and time ticks through the input stream and
// predicts every result with a local zone and dwell-timer model. Results are
// compared field by field in order. The run covers a directed table and
// random zone walks under several dwell settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module proximity_zone_dwell_controller_tb;
	import pzdc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned PHASE_ITEMS = 235;

	localparam logic [15:0] MM_PUBLIC_ABOVE = 16'd4000;
	localparam logic [15:0] MM_SOC_PUBLIC_ABOVE = 16'd3500;
	localparam logic [15:0] MM_SOCIAL_ABOVE = 16'd2000;
	localparam logic [15:0] MM_PERS_SOCIAL_ABOVE = 16'd1500;

	// The register index that has no dwell register behind it.
	localparam logic [1:0] REG_IDX_SPARE = 2'd3;

	localparam logic [15:0] BOUNDARY_MM [8] = '{
		16'd1500, 16'd1501, 16'd2000, 16'd2001, 16'd3500, 16'd3501, 16'd4000, 16'd4001
	};

	typedef struct packed {
		op_t         op;
		logic [15:0] mm;
		logic        fixed;
		result_t     res;
	} stim_row_t;

	localparam result_t AT_REST = '{
		desired_distance_mm: 12'd3500,
		desired_zone: ZONE_SOC_PUBLIC,
		zone_changed: 1'b0,
		previous_zone: ZONE_PUBLIC,
		current_zone: ZONE_PUBLIC
	};
	localparam result_t NO_FIXED = '0;

	// Thresholds from both sides, a full dwell with the reset limit of five
	// ticks, the way down to personal and a jump straight from public.
	localparam stim_row_t DIRECTED_ROWS [21] = '{
		'{OP_MEASURE, 16'hFFFF, 1'b1, AT_REST},
		'{OP_TICK,    16'hFFFF, 1'b1, AT_REST},
		'{OP_MEASURE, 16'd4001, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd4000, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd3501, 1'b0, NO_FIXED},
		'{OP_TICK,    16'h5555, 1'b0, NO_FIXED},
		'{OP_TICK,    16'hAAAA, 1'b0, NO_FIXED},
		'{OP_TICK,    16'd0,    1'b0, NO_FIXED},
		'{OP_TICK,    16'd0,    1'b0, NO_FIXED},
		'{OP_TICK,    16'd0,    1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd3501, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd3500, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd2001, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd2000, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd1501, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd1500, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd0,    1'b0, NO_FIXED},
		'{OP_TICK,    16'd0,    1'b0, NO_FIXED},
		'{OP_MEASURE, 16'hFFFF, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd1500, 1'b0, NO_FIXED},
		'{OP_MEASURE, 16'd4001, 1'b0, NO_FIXED}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	// Local copy of the block's zone state and dwell limits.
	zone_t       zone_now;
	zone_t       zone_prior;
	zone_t       zone_goal;
	logic [15:0] dwell_cnt [NUM_TMR];
	logic        dwell_run [NUM_TMR];
	dwell_cfg_t  dwell_lim;

	result_t     zone_results_q [$];
	result_t     got_res;
	result_t     want_res;

	proximity_zone_dwell_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic zone_t zone_of_mm(input logic [15:0] mm);
		if (mm > MM_PUBLIC_ABOVE) return ZONE_PUBLIC;
		if (mm > MM_SOC_PUBLIC_ABOVE) return ZONE_SOC_PUBLIC;
		if (mm > MM_SOCIAL_ABOVE) return ZONE_SOCIAL;
		if (mm > MM_PERS_SOCIAL_ABOVE) return ZONE_PERS_SOCIAL;
		return ZONE_PERSONAL;
	endfunction

	function automatic logic [11:0] zone_target_mm(input zone_t z);
		case (z)
			ZONE_PERSONAL:    return 12'd500;
			ZONE_PERS_SOCIAL: return 12'd1500;
			ZONE_SOCIAL:      return 12'd2000;
			ZONE_SOC_PUBLIC:  return 12'd3500;
			default:          return 12'd4000;
		endcase
	endfunction

	function automatic void start_dwell(input tmr_idx_t t);
		dwell_cnt[t] = '0;
		dwell_run[t] = 1'b1;
	endfunction

	// Staying in a zone: a running timer that has met its limit moves the
	// goal one zone closer; a stopped timer is restarted.
	function automatic void try_dwell_step(input tmr_idx_t t, input logic [15:0] lim,
			input zone_t next_zone);
		if (zone_goal == next_zone) return;
		if (dwell_run[t]) begin
			if (dwell_cnt[t] >= lim) begin
				zone_goal = next_zone;
				dwell_run[t] = 1'b0;
			end
		end else begin
			start_dwell(t);
		end
	endfunction

	function automatic result_t predict_zone_item(input op_t op, input logic [15:0] mm);
		result_t r;
		zone_t   z;
		zone_t   prev;
		logic    moved;
		prev = zone_now;
		moved = 1'b0;
		if (op == OP_MEASURE) begin
			z = zone_of_mm(mm);
			moved = (z != zone_now);
			if (moved) begin
				case (z)
					ZONE_PUBLIC: begin
						dwell_run[TMR_SOC_PUBLIC] = 1'b0;
						zone_goal = ZONE_SOC_PUBLIC;
					end
					ZONE_SOC_PUBLIC: begin
						start_dwell(TMR_SOC_PUBLIC);
						dwell_run[TMR_SOCIAL] = 1'b0;
					end
					ZONE_SOCIAL: begin
						start_dwell(TMR_SOCIAL);
						dwell_run[TMR_PERS_SOCIAL] = 1'b0;
						dwell_run[TMR_SOC_PUBLIC] = 1'b0;
					end
					ZONE_PERS_SOCIAL: begin
						start_dwell(TMR_PERS_SOCIAL);
						dwell_run[TMR_SOCIAL] = 1'b0;
					end
					default: dwell_run[TMR_PERS_SOCIAL] = 1'b0;
				endcase
			end else begin
				case (z)
					ZONE_PUBLIC:      zone_goal = ZONE_SOC_PUBLIC;
					ZONE_SOC_PUBLIC:  try_dwell_step(TMR_SOC_PUBLIC, dwell_lim.dwell_soc_public,
						ZONE_SOCIAL);
					ZONE_SOCIAL:      try_dwell_step(TMR_SOCIAL, dwell_lim.dwell_social,
						ZONE_PERS_SOCIAL);
					ZONE_PERS_SOCIAL: try_dwell_step(TMR_PERS_SOCIAL,
						dwell_lim.dwell_pers_social, ZONE_PERSONAL);
					default:          dwell_run[TMR_PERS_SOCIAL] = 1'b0;
				endcase
			end
			zone_now = z;
			zone_prior = z;
		end else begin
			for (int i = 0; i < NUM_TMR; i++) begin
				if (dwell_run[i] && dwell_cnt[i] != COUNT_MAX) dwell_cnt[i] = dwell_cnt[i] + 16'd1;
			end
			prev = zone_prior;
		end
		r.current_zone = zone_now;
		r.previous_zone = prev;
		r.zone_changed = moved;
		r.desired_zone = zone_goal;
		r.desired_distance_mm = zone_target_mm(zone_goal);
		return r;
	endfunction

	function automatic logic [15:0] mm_in_zone(input int z);
		case (z)
			0:       return 16'($urandom_range(1500, 0));
			1:       return 16'($urandom_range(2000, 1501));
			2:       return 16'($urandom_range(3500, 2001));
			3:       return 16'($urandom_range(4000, 3501));
			default: return 16'($urandom_range(65535, 4001));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_item(input op_t op, input logic [15:0] mm, input logic fixed,
			input result_t fixed_res);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= mm;
		do @(posedge clk); while (!s_tready);
		predicted = predict_zone_item(op, mm);
		zone_results_q.push_back(fixed ? fixed_res : predicted);
	endtask

	// Holds the input side off until every predicted result has come back,
	// then lets the pipeline settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (zone_results_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_dwell(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DWELL_SOC_PUBLIC:  dwell_lim.dwell_soc_public = val;
			REG_DWELL_SOCIAL:      dwell_lim.dwell_social = val;
			REG_DWELL_PERS_SOCIAL: dwell_lim.dwell_pers_social = val;
			default: ;
		endcase
	endtask

	task automatic set_dwell_limits(input logic [15:0] soc_public, input logic [15:0] social,
			input logic [15:0] pers_social, input logic poke_spare);
		write_dwell(REG_DWELL_SOC_PUBLIC, soc_public);
		write_dwell(REG_DWELL_SOCIAL, social);
		write_dwell(REG_DWELL_PERS_SOCIAL, pers_social);
		if (poke_spare) write_dwell(REG_IDX_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Random zone walk: mostly ticks and measurements near the walking zone so
	// that dwell limits get reached, with threshold values and raw noise mixed in.
	task automatic run_zone_walk(input int unsigned n, input int unsigned idle_pct,
			input int unsigned stall, input logic pause_mid);
		int          walk;
		int unsigned pick;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		walk = int'(zone_now);
		for (int unsigned i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) wait_drained();
			if ($urandom_range(5) == 0) begin
				if ($urandom_range(1) == 1) walk = (walk < 4) ? walk + 1 : walk;
				else walk = (walk > 0) ? walk - 1 : walk;
			end
			pick = $urandom_range(99);
			if (pick < 45) send_item(OP_TICK, 16'($urandom), 1'b0, NO_FIXED);
			else if (pick < 80) send_item(OP_MEASURE, mm_in_zone(walk), 1'b0, NO_FIXED);
			else if (pick < 90) send_item(OP_MEASURE, BOUNDARY_MM[$urandom_range(7)], 1'b0,
				NO_FIXED);
			else send_item(OP_MEASURE, 16'($urandom), 1'b0, NO_FIXED);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (zone_results_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", m_tdata, '0);
			end else begin
				want_res = zone_results_q.pop_front();
				got_res = m_tdata[21:0];
				if (got_res.current_zone !== want_res.current_zone)
					report_mismatch("current_zone", 24'(got_res.current_zone),
						24'(want_res.current_zone));
				if (got_res.previous_zone !== want_res.previous_zone)
					report_mismatch("previous_zone", 24'(got_res.previous_zone),
						24'(want_res.previous_zone));
				if (got_res.zone_changed !== want_res.zone_changed)
					report_mismatch("zone_changed", 24'(got_res.zone_changed),
						24'(want_res.zone_changed));
				if (got_res.desired_zone !== want_res.desired_zone)
					report_mismatch("desired_zone", 24'(got_res.desired_zone),
						24'(want_res.desired_zone));
				if (got_res.desired_distance_mm !== want_res.desired_distance_mm)
					report_mismatch("desired_distance_mm", 24'(got_res.desired_distance_mm),
						24'(want_res.desired_distance_mm));
				if (m_tdata[23:22] !== 2'b00)
					report_mismatch("tdata padding", 24'(m_tdata[23:22]), '0);
			end
		end
	end

	// Ends a hung run: counts cycles in which no transaction happens anywhere.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		zone_now = ZONE_PUBLIC;
		zone_prior = ZONE_PUBLIC;
		zone_goal = ZONE_SOC_PUBLIC;
		for (int i = 0; i < NUM_TMR; i++) begin
			dwell_cnt[i] = '0;
			dwell_run[i] = 1'b0;
		end
		dwell_lim = '{dwell_pers_social: 16'd5, dwell_social: 16'd5, dwell_soc_public: 16'd5};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].mm, DIRECTED_ROWS[i].fixed,
				DIRECTED_ROWS[i].res);
		wait_drained();

		set_dwell_limits(16'd0, 16'd0, 16'd0, 1'b0);
		run_zone_walk(PHASE_ITEMS, 0, 0, 1'b0);

		set_dwell_limits(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
			16'($urandom_range(8, 1)), 1'b0);
		run_zone_walk(PHASE_ITEMS, 70, 0, 1'b1);

		set_dwell_limits(16'hFFFF, 16'($urandom_range(8, 0)), 16'hFFFF, 1'b1);
		run_zone_walk(PHASE_ITEMS, 0, 70, 1'b0);

		set_dwell_limits(16'($urandom_range(6, 0)), 16'($urandom_range(6, 0)),
			16'($urandom), 1'b1);
		run_zone_walk(PHASE_ITEMS, 21, 21, 1'b0);

		repeat (5) @(posedge clk);
		if (zone_results_q.size() != 0)
			report_mismatch("results never delivered", 24'(zone_results_q.size()), '0);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
